[hdl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DEQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

  // value shown at both ends while the queue is empty
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  localparam logic [CNT_OUT_W-1:0] FULL_COUNT_OUT = CNT_OUT_W'(DEPTH);

endpackage

[hdl/deq_ram.sv]
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/double_ended_queue_core.sv]
// bounded double-ended queue of 32-bit signed values, 16 entries
//
// input channel (in_valid / in_ready): cmd and value. cmd 0 queries, 1 pushes
// value at the back, 2 at the front, 3 pops the front, 4 pops the back; codes
// 5 to 7 act as a query. a pop on an empty queue or a push on a full one
// changes nothing and returns error = 1.
// output channel (out_valid / out_ready): one result per item with the front
// and back values (-1 when empty), count, empty_res, full_res and error.
// the result passes the pending stage, then the output register, before
// it is offered. throughput: one item per cycle while the receiver keeps up.
// the pointers and count update at the accept edge, the two mirrored ring
// memories are read in the same cycle, and a value pushed by that item is
// forwarded around the memory read. the read data sit in a pending stage
// ahead of the output register, so the input stays open while a finished
// result waits to be taken. receiver stall: once both the pending stage and
// the output register are full, in_ready drops until out_ready frees a slot.
// reset: synchronous, clears pointers, count and both stages; the memories
// keep their contents, which are never read before being written.
module double_ended_queue_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [deq_pkg::CMD_W-1:0]                cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]        value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [deq_pkg::DATA_W-1:0]        front_value,
  output logic signed [deq_pkg::DATA_W-1:0]        back_value,
  output logic [deq_pkg::CNT_OUT_W-1:0]            count,
  output logic                                     empty_res,
  output logic                                     full_res,
  output logic                                     error
);

  function automatic logic [deq_pkg::ADDR_W-1:0] ptr_up(input logic [deq_pkg::ADDR_W-1:0] p);
    ptr_up = (p == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [deq_pkg::ADDR_W-1:0] ptr_down(input logic [deq_pkg::ADDR_W-1:0] p);
    ptr_down = (p == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : p - 1'b1;
  endfunction

  logic [deq_pkg::ADDR_W-1:0] head, head_next;
  logic [deq_pkg::ADDR_W-1:0] tail, tail_next;
  logic [deq_pkg::CNT_W-1:0]  fill_count, fill_count_next;

  logic                       accept;
  logic                       is_empty, is_full;
  logic                       wr_en;
  logic [deq_pkg::ADDR_W-1:0] wr_addr;
  logic                       err_now;
  logic [deq_pkg::ADDR_W-1:0] front_addr, back_addr;
  logic [deq_pkg::DATA_W-1:0] front_rdata, back_rdata;

  // pending stage: memory read data plus what the item decided
  logic                       pend_valid;
  logic                       pend_move;
  logic [deq_pkg::CNT_W-1:0]  pend_cnt;
  logic                       pend_err;
  logic                       pend_fwd_front;
  logic                       pend_fwd_back;
  logic [deq_pkg::DATA_W-1:0] pend_wval;
  logic                       pend_empty;
  logic                       pend_full;

  assign accept    = in_valid && in_ready;
  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = !pend_valid || pend_move;

  assign is_empty = (fill_count == '0);
  assign is_full  = (fill_count >= deq_pkg::CNT_W'(deq_pkg::DEPTH));

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    fill_count_next = fill_count;
    wr_en           = 1'b0;
    wr_addr         = tail;
    err_now         = 1'b0;
    case (cmd)
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          err_now = 1'b1;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = tail;
          tail_next       = ptr_up(tail);
          fill_count_next = fill_count + 1'b1;
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          err_now = 1'b1;
        end else begin
          wr_en           = 1'b1;
          head_next       = ptr_down(head);
          wr_addr         = ptr_down(head);
          fill_count_next = fill_count + 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          err_now = 1'b1;
        end else begin
          head_next       = ptr_up(head);
          fill_count_next = fill_count - 1'b1;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          err_now = 1'b1;
        end else begin
          tail_next       = ptr_down(tail);
          fill_count_next = fill_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign front_addr = head_next;
  assign back_addr  = ptr_down(tail_next);

  // two copies of the ring so both ends can be read in the same cycle
  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(deq_pkg::DEPTH)
  ) u_front_ram (
    .clk  (clk),
    .we   (accept && wr_en),
    .waddr(wr_addr),
    .wdata(value),
    .re   (accept),
    .raddr(front_addr),
    .rdata(front_rdata)
  );

  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(deq_pkg::DEPTH)
  ) u_back_ram (
    .clk  (clk),
    .we   (accept && wr_en),
    .waddr(wr_addr),
    .wdata(value),
    .re   (accept),
    .raddr(back_addr),
    .rdata(back_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fill_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        head       <= head_next;
        tail       <= tail_next;
        fill_count <= fill_count_next;
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cnt       <= fill_count_next;
      pend_err       <= err_now;
      pend_empty     <= (fill_count_next == '0);
      pend_full      <= (fill_count_next >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
      // a value written this cycle is not yet visible through the read port
      pend_fwd_front <= wr_en && (wr_addr == front_addr);
      pend_fwd_back  <= wr_en && (wr_addr == back_addr);
      pend_wval      <= value;
    end
    if (pend_move) begin
      if (pend_empty) begin
        front_value <= deq_pkg::EMPTY_VALUE;
        back_value  <= deq_pkg::EMPTY_VALUE;
      end else begin
        front_value <= pend_fwd_front ? pend_wval : front_rdata;
        back_value  <= pend_fwd_back ? pend_wval : back_rdata;
      end
      count     <= deq_pkg::CNT_OUT_W'(pend_cnt);
      empty_res <= pend_empty;
      full_res  <= pend_full;
      error     <= pend_err;
    end
  end

endmodule

[hdl/deq_checker.sv]
`include "assert_macros.svh"

module deq_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic signed [deq_pkg::DATA_W-1:0]        front_value,
  input logic signed [deq_pkg::DATA_W-1:0]        back_value,
  input logic [deq_pkg::CNT_OUT_W-1:0]            count,
  input logic                                     empty_res,
  input logic                                     full_res,
  input logic                                     error
);

  // a result offered and not taken stays offered
  `DEQ_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // an empty queue shows -1 at both ends and a zero count
  `DEQ_ASSERT(a_empty_view, clk, rst, out_valid && empty_res |-> count == '0 && front_value == deq_pkg::EMPTY_VALUE && back_value == deq_pkg::EMPTY_VALUE, "empty result inconsistent")

  // a single stored value is both front and back
  `DEQ_ASSERT(a_single, clk, rst, out_valid && count == 5'd1 && !full_res |-> front_value == back_value && !empty_res, "single entry ends differ")

  // full flag agrees with the count and excludes empty
  `DEQ_ASSERT(a_full_view, clk, rst, out_valid && full_res |-> count == deq_pkg::FULL_COUNT_OUT && !empty_res, "full result inconsistent")

  // nothing is offered right after reset
  `DEQ_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result offered after reset")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
